FILE: hdl/rm2eul_pkg.sv
// ============================================================================
// rm2eul_pkg
// Shared constants and the arctangent table for the Euler angle unit.
// ============================================================================
`default_nettype none

package rm2eul_pkg;

    localparam int DATA_W            = 16;
    localparam int S_TDATA_W         = 112;
    localparam int M_TDATA_W         = 48;
    localparam int ANGLE_Y_W         = 15;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int IN_FRAC_BITS_DEF  = 14;

    // Angles inside the datapath carry 40 fraction bits.
    localparam int ANG_FRAC          = 40;
    localparam int ZW                = 45;
    localparam int VEC_SHIFT         = 16;
    localparam int OUT_SHIFT         = 27;
    localparam int Q13_PI            = 25736;
    localparam int Q13_HALF_PI       = 12868;

    // One third at 2^-40 scale, the first term of the atan(1/3) series.
    localparam longint unsigned RECIP3_Q40 = (longint'(1) << ANG_FRAC) / 3;

    // Truncating unsigned division by shift and subtract, used only while
    // the arctangent table is built at elaboration.
    function automatic longint unsigned udiv(input longint unsigned n,
                                             input longint unsigned d);
        longint unsigned q;
        longint unsigned rem;
        q   = 0;
        rem = 0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], n[b]};
            if (rem >= d) begin
                rem  = rem - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(2^-i) at 2^-40 scale, summed as an alternating series with
    // truncating division. Entry 0 is atan(1/2) + atan(1/3).
    function automatic longint atan_entry(input int i);
        longint unsigned p;
        longint          sum;
        longint          term;
        sum = 0;
        if (i == 0) begin
            p = longint'(1) << (ANG_FRAC - 1);
            for (int k = 0; k < 64; k++) begin
                if (p != 0) begin
                    term = longint'(udiv(p, longint'(2 * k + 1)));
                    sum  = k[0] ? sum - term : sum + term;
                    p    = p >> 2;
                end
            end
            p = RECIP3_Q40;
            for (int k = 0; k < 64; k++) begin
                if (p != 0) begin
                    term = longint'(udiv(p, longint'(2 * k + 1)));
                    sum  = k[0] ? sum - term : sum + term;
                    p    = udiv(p, 9);
                end
            end
        end else begin
            p = longint'(1) << (ANG_FRAC - i);
            for (int k = 0; k < 64; k++) begin
                if (p != 0) begin
                    term = longint'(udiv(p, longint'(2 * k + 1)));
                    sum  = k[0] ? sum - term : sum + term;
                    p    = p >> (2 * i);
                end
            end
        end
        return sum;
    endfunction

    localparam longint PI40 = 4 * atan_entry(0);

endpackage

`default_nettype wire

FILE: hdl/rm2eul_sqrt_cell.sv
// ============================================================================
// rm2eul_sqrt_cell
// One digit step of a restoring integer square root, with a side payload.
// ============================================================================
`default_nettype none

module rm2eul_sqrt_cell #(
    parameter int VW      = 29,
    parameter int PW      = 8,
    parameter int BIT_POS = 28
) (
    input  wire logic          aclk,
    input  wire logic          en,
    input  wire logic [VW-1:0] v_in,
    input  wire logic [VW-1:0] res_in,
    input  wire logic [PW-1:0] pay_in,
    output logic      [VW-1:0] v_out,
    output logic      [VW-1:0] res_out,
    output logic      [PW-1:0] pay_out
);
    localparam logic [VW:0] BIT = (VW + 1)'(1) << BIT_POS;

    logic [VW:0] trial;
    logic [VW-1:0] v_reg, v_next, res_reg, res_next;
    logic [PW-1:0] pay_reg;

    always_comb begin
        trial = {1'b0, res_in} + BIT;
        if ({1'b0, v_in} >= trial) begin
            v_next   = VW'({1'b0, v_in} - trial);
            res_next = VW'({2'b0, res_in[VW-1:1]} + BIT);
        end else begin
            v_next   = v_in;
            res_next = {1'b0, res_in[VW-1:1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            v_reg   <= v_next;
            res_reg <= res_next;
            pay_reg <= pay_in;
        end
    end

    assign v_out   = v_reg;
    assign res_out = res_reg;
    assign pay_out = pay_reg;

endmodule

`default_nettype wire

FILE: hdl/rm2eul_cordic_cell.sv
// ============================================================================
// rm2eul_cordic_cell
// One vectoring micro-rotation of the CORDIC chain.
// ============================================================================
`default_nettype none

module rm2eul_cordic_cell #(
    parameter int XW    = 36,
    parameter int STAGE = 0
) (
    input  wire logic                          aclk,
    input  wire logic                          en,
    input  wire logic signed [XW-1:0]          x_in,
    input  wire logic signed [XW-1:0]          y_in,
    input  wire logic signed [rm2eul_pkg::ZW-1:0] z_in,
    output logic signed      [XW-1:0]          x_out,
    output logic signed      [XW-1:0]          y_out,
    output logic signed      [rm2eul_pkg::ZW-1:0] z_out
);
    import rm2eul_pkg::*;

    localparam logic signed [ZW-1:0] ANG = ZW'(atan_entry(STAGE));

    logic signed [XW-1:0] dx, dy;
    logic signed [XW-1:0] x_reg, y_reg;
    logic signed [ZW-1:0] z_reg;

    assign dx = y_in >>> STAGE;
    assign dy = x_in >>> STAGE;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (y_in > 0) begin
                x_reg <= x_in + dx;
                y_reg <= y_in - dy;
                z_reg <= z_in + ANG;
            end else begin
                x_reg <= x_in - dx;
                y_reg <= y_in + dy;
                z_reg <= z_in - ANG;
            end
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

`default_nettype wire

FILE: hdl/rm2eul_atan2_chain.sv
// ============================================================================
// rm2eul_atan2_chain
// Pipelined atan2: quadrant fold, a row of CORDIC cells, rounding and clamping to Q3.13.
// ============================================================================
`default_nettype none

module rm2eul_atan2_chain #(
    parameter int STAGES = 16,
    parameter int IW     = 17,
    parameter bit NEG    = 1'b0
) (
    input  wire logic                 aclk,
    input  wire logic                 en,
    input  wire logic signed [IW-1:0] y_in,
    input  wire logic signed [IW-1:0] x_in,
    output logic signed      [rm2eul_pkg::DATA_W-1:0] angle_out
);
    import rm2eul_pkg::*;

    localparam int XW = IW + VEC_SHIFT + 3;
    localparam int RW = ZW - OUT_SHIFT;
    localparam logic signed [ZW-1:0] PI_Z = ZW'(PI40);
    localparam logic signed [ZW-1:0] HALF_LSB = ZW'(1) << (OUT_SHIFT - 1);

    logic signed [XW-1:0] x_s [0:STAGES];
    logic signed [XW-1:0] y_s [0:STAGES];
    logic signed [ZW-1:0] z_s [0:STAGES];
    logic [STAGES:0]      zero_line_reg;

    logic signed [XW-1:0] xs, ys;
    logic signed [ZW-1:0] a, a_rnd;
    logic signed [RW-1:0] r;
    logic signed [DATA_W-1:0] angle_reg, angle_next;

    assign xs = XW'(x_in) <<< VEC_SHIFT;
    assign ys = XW'(y_in) <<< VEC_SHIFT;

    // Fold the left half-plane onto the right, starting from plus or minus pi.
    always_ff @(posedge aclk) begin
        if (en) begin
            zero_line_reg <= {zero_line_reg[STAGES-1:0], (x_in == 0) && (y_in == 0)};
            if (x_in < 0) begin
                x_s[0] <= -xs;
                y_s[0] <= -ys;
                z_s[0] <= (y_in >= 0) ? PI_Z : -PI_Z;
            end else begin
                x_s[0] <= xs;
                y_s[0] <= ys;
                z_s[0] <= '0;
            end
        end
    end

    for (genvar g = 0; g < STAGES; g++) begin : g_cell
        rm2eul_cordic_cell #(
            .XW    (XW),
            .STAGE (g)
        ) u_cell (
            .aclk  (aclk),
            .en    (en),
            .x_in  (x_s[g]),
            .y_in  (y_s[g]),
            .z_in  (z_s[g]),
            .x_out (x_s[g+1]),
            .y_out (y_s[g+1]),
            .z_out (z_s[g+1])
        );
    end

    always_comb begin
        a     = NEG ? -z_s[STAGES] : z_s[STAGES];
        a_rnd = a + HALF_LSB;
        r     = RW'(a_rnd >>> OUT_SHIFT);
        if (zero_line_reg[STAGES]) begin
            angle_next = '0;
        end else if (r > RW'(Q13_PI)) begin
            angle_next = DATA_W'(Q13_PI);
        end else if (r < -RW'(Q13_PI)) begin
            angle_next = -DATA_W'(Q13_PI);
        end else begin
            angle_next = DATA_W'(r);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            angle_reg <= angle_next;
        end
    end

    assign angle_out = angle_reg;

endmodule

`default_nettype wire

FILE: hdl/rotation_matrix_to_euler_angles_unit.sv
// ============================================================================
// rotation_matrix_to_euler_angles_unit
// ZYX Euler angles (Q3.13 radians) from a Q2.14 rotation matrix.
// ============================================================================
//
//  Channel | Direction | Beat contents (lowest bits first)
//  --------+-----------+---------------------------------------------------
//  s_      | in        | tdata: r00, r01, r02, r10, r20, r21, r22 (16 b each)
//  m_      | out       | tdata: angle_x(16), angle_y(15), angle_z(16), pad;
//          |           | tuser: gimbal_lock
//
// One matrix is accepted every cycle while the row is not held. The pipeline
// has one input stage, IN_FRAC_BITS + 1 square-root digit cells, then
// the three CORDIC rows (fold stage, CORDIC_STAGES cells, rounding register).
// The whole row advances together; it holds only when a result sits in the
// output register and the sink is not ready. Reset clears the valid line only.
`default_nettype none

module rotation_matrix_to_euler_angles_unit #(
    parameter int CORDIC_STAGES = rm2eul_pkg::CORDIC_STAGES_DEF,
    parameter int IN_FRAC_BITS  = rm2eul_pkg::IN_FRAC_BITS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // r00, r01, r02, r10, r20, r21, r22 from bit 0 up, 16 bits each.
    input  wire logic [rm2eul_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // angle_x [15:0], angle_y [30:16], angle_z [46:31], zero at bit 47.
    output logic [rm2eul_pkg::M_TDATA_W-1:0]      m_tdata,
    // gimbal_lock at bit 0.
    output logic                                  m_tuser
);
    import rm2eul_pkg::*;

    localparam int F     = IN_FRAC_BITS;
    // Operand width: holds a clamped r20, a negated 16-bit element and sqrt.
    localparam int IW    = (F + 2 > DATA_W + 1) ? F + 2 : DATA_W + 1;
    localparam int VW    = 2 * F + 1;
    localparam int SQ    = F + 1;
    localparam int CL    = CORDIC_STAGES + 2;
    localparam int DEPTH = 1 + SQ + CL;
    // Payload riding along the root cells: r20, ax y/x, az y/x, lock, sign.
    localparam int PW    = 5 * IW + 2;

    localparam logic signed [IW-1:0] ONE = IW'(1) << F;

    logic en;
    logic [DEPTH-1:0] vld_reg;

    // The row moves whenever the output register is empty or being drained.
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[DEPTH-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[DEPTH-2:0], s_tvalid};
        end
    end

    // ---------------------------------------------------------------- input
    logic signed [IW-1:0] r00, r01, r02, r10, r20, r21, r22, r20c;
    logic signed [IW-1:0] axy, axx;
    logic                 lock_pos, lock_neg;
    logic [F:0]           mag;
    logic [VW-1:0]        v0;

    assign r00 = IW'($signed(s_tdata[15:0]));
    assign r01 = IW'($signed(s_tdata[31:16]));
    assign r02 = IW'($signed(s_tdata[47:32]));
    assign r10 = IW'($signed(s_tdata[63:48]));
    assign r20 = IW'($signed(s_tdata[79:64]));
    assign r21 = IW'($signed(s_tdata[95:80]));
    assign r22 = IW'($signed(s_tdata[111:96]));

    always_comb begin
        if (r20 > ONE) begin
            r20c = ONE;
        end else if (r20 < -ONE) begin
            r20c = -ONE;
        end else begin
            r20c = r20;
        end
        lock_pos = (r20c == ONE);
        lock_neg = (r20c == -ONE);
        mag      = (F + 1)'(r20c < 0 ? -r20c : r20c);
        // At lock the magnitude is one and the radicand comes out zero.
        v0       = (VW'(1) << (2 * F)) - VW'(mag * mag);
        if (lock_pos) begin
            axy = -r01;
            axx = -r02;
        end else if (lock_neg) begin
            axy = r01;
            axx = r02;
        end else begin
            axy = r21;
            axx = r22;
        end
    end

    logic [VW-1:0] v_s   [0:SQ];
    logic [VW-1:0] res_s [0:SQ];
    logic [PW-1:0] pay_s [0:SQ];

    always_ff @(posedge aclk) begin
        if (en) begin
            v_s[0]   <= v0;
            res_s[0] <= '0;
            pay_s[0] <= {lock_pos, lock_pos || lock_neg, r00, r10, axx, axy, r20c};
        end
    end

    // ------------------------------------------------ square root of 1 - r20^2
    for (genvar g = 0; g < SQ; g++) begin : g_sqrt
        rm2eul_sqrt_cell #(
            .VW      (VW),
            .PW      (PW),
            .BIT_POS (2 * (F - g))
        ) u_sqrt (
            .aclk    (aclk),
            .en      (en),
            .v_in    (v_s[g]),
            .res_in  (res_s[g]),
            .pay_in  (pay_s[g]),
            .v_out   (v_s[g+1]),
            .res_out (res_s[g+1]),
            .pay_out (pay_s[g+1])
        );
    end

    logic signed [IW-1:0] c_val, p_r20, p_axy, p_axx, p_r10, p_r00;
    logic                 p_lock, p_pos;

    assign c_val = IW'({1'b0, res_s[SQ][F:0]});
    assign {p_pos, p_lock, p_r00, p_r10, p_axx, p_axy, p_r20} = pay_s[SQ];

    // --------------------------------------------------------- CORDIC rows
    logic signed [DATA_W-1:0] ax_q, ay_q, az_q;

    rm2eul_atan2_chain #(
        .STAGES (CORDIC_STAGES),
        .IW     (IW),
        .NEG    (1'b0)
    ) u_ax (
        .aclk      (aclk),
        .en        (en),
        .y_in      (p_axy),
        .x_in      (p_axx),
        .angle_out (ax_q)
    );

    // angle_y = -asin(r20), taken as -atan2(r20, sqrt(1 - r20^2)).
    rm2eul_atan2_chain #(
        .STAGES (CORDIC_STAGES),
        .IW     (IW),
        .NEG    (1'b1)
    ) u_ay (
        .aclk      (aclk),
        .en        (en),
        .y_in      (p_r20),
        .x_in      (c_val),
        .angle_out (ay_q)
    );

    rm2eul_atan2_chain #(
        .STAGES (CORDIC_STAGES),
        .IW     (IW),
        .NEG    (1'b0)
    ) u_az (
        .aclk      (aclk),
        .en        (en),
        .y_in      (p_r10),
        .x_in      (p_r00),
        .angle_out (az_q)
    );

    // Lock flags follow the CORDIC rows so they line up with the angles.
    logic [CL-1:0] lock_line_reg, pos_line_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            lock_line_reg <= {lock_line_reg[CL-2:0], p_lock};
            pos_line_reg  <= {pos_line_reg[CL-2:0], p_pos};
        end
    end

    // --------------------------------------------------------------- output
    logic                 out_lock;
    logic signed [DATA_W-1:0] ay_sel, az_sel;

    assign out_lock = lock_line_reg[CL-1];

    // At lock, r20 = +1 gives -pi/2 and r20 = -1 gives +pi/2; angle_z is zero.
    always_comb begin
        if (out_lock) begin
            ay_sel = pos_line_reg[CL-1] ? -DATA_W'(Q13_HALF_PI) : DATA_W'(Q13_HALF_PI);
            az_sel = '0;
        end else begin
            ay_sel = ay_q;
            az_sel = az_q;
        end
    end

    assign m_tdata = {1'b0, az_sel, ay_sel[ANGLE_Y_W-1:0], ax_q};
    assign m_tuser = out_lock;

endmodule

`default_nettype wire

FILE: hdl/rm2eul_checker.sv
// ============================================================================
// rm2eul_checker
// Port-level checks for the Euler angle unit, bound to the top level.
// ============================================================================
`default_nettype none

module rm2eul_checker (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic                             s_tvalid,
    input wire logic                             s_tready,
    input wire logic [rm2eul_pkg::S_TDATA_W-1:0] s_tdata,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    input wire logic [rm2eul_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic                             m_tuser
);
    import rm2eul_pkg::*;

    // A stalled result stays put with its data.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Input is refused only while a result waits on a stalled sink.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");

    // At gimbal lock angle_z is zero and angle_y sits at plus or minus pi/2.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> (m_tdata[46:31] == 16'd0) &&
        ((m_tdata[30:16] == 15'(Q13_HALF_PI)) || (m_tdata[30:16] == 15'(-Q13_HALF_PI))))
        else $error("lock result has wrong angles");

    // angle_x never leaves the range of plus or minus pi.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[15:0]) <= 16'sd25736) &&
        ($signed(m_tdata[15:0]) >= -16'sd25736))
        else $error("angle_x out of range");

endmodule

bind rotation_matrix_to_euler_angles_unit rm2eul_checker u_rm2eul_checker (.*);

`default_nettype wire
